@@ rtl/pgmem_pkg.sv @@
// ----------------------------------------------------------------------------
// pgmem_pkg
// Shared types and constants of the paged memory allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pgmem_pkg;

  localparam int OFFSET_BITS      = 8;
  localparam int PAGE_NUMBER_BITS = 6;
  localparam int ADDR_BITS        = OFFSET_BITS + PAGE_NUMBER_BITS;
  localparam int PG_COUNT         = 1 << PAGE_NUMBER_BITS;
  localparam int MEM_BYTES        = 1 << ADDR_BITS;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_UNMAPPED = 2'd2,
    ST_BADSIZE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_XLATE,
    S_RAMRD,
    S_ARD,
    S_AEX,
    S_AEND,
    S_FRD,
    S_FEX,
    S_SRD,
    S_SEX,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e          command;
    logic [2:0]    process_id;
    logic [13:0]   address;
    logic [14:0]   size_bytes;
    logic [7:0]    write_data;
  } req_t;

  typedef struct packed {
    status_e       status;
    logic [13:0]   region_start;
    logic [7:0]    read_data;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/paged_memory_alloc_translate.sv @@
// ----------------------------------------------------------------------------
// paged_memory_alloc_translate
// Paged byte memory with per-process allocation and address translation.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. After reset the block runs a
// clearing pass over all 16384 RAM bytes (one RAM byte a cycle; owner and
// translation stores are cleared along the way) and stalls requests until it
// is done. Then one request is worked at a time by a sequencer around four
// synchronous stores with one write port and one registered read port each
// (page owner, page link, translation map, byte RAM):
//   read            : decode, map read, RAM read, result
//   write           : decode, map read with RAM write, result
//   bad process id  : decode, result
//   allocate        : decode, then a scan of the owner store from physical
//                     page 0 up to the last page taken, then result
//   free            : decode, map read, a walk of the page chain that
//                     releases each page of the process, then a shrink of
//                     the break down past unmapped pages, stopping at a
//                     mapped page; the walk stops at the chain end or at a
//                     page of another owner (unmapped start address: decode, map read, result)
// A finished result sits in the output register while the next request is
// taken. Break pointers are kept in pages, per process, in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_memory_alloc_translate #(
  parameter int PROCESS_COUNT = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  input  pgmem_pkg::req_t  req,
  output logic             rsp_valid,
  input  wire              rsp_stall,
  output pgmem_pkg::rsp_t  rsp
);
  import pgmem_pkg::*;

  localparam int PID_BITS  = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int MAP_DEPTH = PROCESS_COUNT * PG_COUNT;
  localparam int MAP_AW    = PID_BITS + PAGE_NUMBER_BITS;
  localparam int PN        = PAGE_NUMBER_BITS;
  localparam logic [4:0]          PCOUNT   = 5'(PROCESS_COUNT);
  localparam logic [ADDR_BITS:0]  MAP_LIM  = (ADDR_BITS+1)'(MAP_DEPTH);
  localparam logic [ADDR_BITS:0]  PG_LIM   = (ADDR_BITS+1)'(PG_COUNT);
  localparam logic [PN:0]         PG_FULL  = (PN+1)'(PG_COUNT);
  localparam logic [PN:0]         LINK_END = {1'b1, {PN{1'b0}}};

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  logic [2:0]    owner_mem [PG_COUNT];
  logic [PN:0]   link_mem  [PG_COUNT];
  logic [PN:0]   map_mem   [MAP_DEPTH];
  logic [7:0]    ram_mem   [MEM_BYTES];

  logic              owner_we;
  logic [PN-1:0]     owner_waddr, owner_raddr;
  logic [2:0]        owner_wdata, owner_rdata;
  logic              link_we;
  logic [PN-1:0]     link_waddr, link_raddr;
  logic [PN:0]       link_wdata, link_rdata;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [PN:0]       map_wdata, map_rdata;
  logic              ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (owner_we) owner_mem[owner_waddr] <= owner_wdata;
    owner_rdata <= owner_mem[owner_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_waddr] <= ram_wdata;
    ram_rdata <= ram_mem[ram_raddr];
  end

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  state_e             state, state_next;
  req_t               item;
  logic [ADDR_BITS-1:0] clr_idx;
  logic [PN:0]        bp_reg [PROCESS_COUNT];
  logic [PN:0]        free_cnt;
  logic [PN-1:0]      scan_pg;     // allocate scan position
  logic [PN-1:0]      prev_pg;     // last page taken
  logic               have_prev;
  logic [PN:0]        cnt;         // pages taken / released
  logic [7:0]         need;        // pages requested
  logic [PN-1:0]      walk_pg;     // free chain position
  status_e            res_status;
  logic [ADDR_BITS-1:0] res_start;
  logic [7:0]         res_data;

  // Derived values
  logic               pid_ok;
  logic [PID_BITS-1:0] pidx;
  logic [PN:0]        bp_cur;
  logic [PN-1:0]      vpage;
  logic [15:0]        size_round;
  logic [7:0]         need_calc;
  logic [8:0]         bp_sum;
  logic [PN:0]        vsum;        // vpage + cnt on free
  logic [PN-1:0]      avpage;      // virtual page of the next alloc mapping
  logic               slot_free;
  logic               own_match;
  logic [PN:0]        bp_dec;

  assign pid_ok     = (item.process_id != 3'd0) && ({2'b0, item.process_id} <= PCOUNT);
  assign pidx       = PID_BITS'(item.process_id - 3'd1);
  assign bp_cur     = bp_reg[pidx];
  assign bp_dec     = bp_cur - 1'b1;
  assign vpage      = item.address[ADDR_BITS-1:OFFSET_BITS];
  assign size_round = {1'b0, item.size_bytes} + 16'((1 << OFFSET_BITS) - 1);
  assign need_calc  = size_round[OFFSET_BITS+7:OFFSET_BITS];
  assign bp_sum     = {2'b0, bp_cur} + {1'b0, need};
  assign vsum       = {1'b0, vpage} + cnt;
  assign avpage     = bp_cur[PN-1:0] + cnt[PN-1:0];
  assign slot_free  = !rsp_valid || !rsp_stall;
  assign own_match  = (owner_rdata == item.process_id);

  assign req_stall  = (state != S_IDLE);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (&clr_idx) state_next = S_IDLE;
      S_IDLE:   if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (!pid_ok) state_next = S_DONE;
        else if (item.command == CMD_ALLOC) begin
          if (item.size_bytes == 15'd0) state_next = S_DONE;
          else if ({1'b0, need_calc} > {2'b0, free_cnt} ||
                   ({1'b0, bp_cur} + {1'b0, need_calc}) > {2'b0, PG_FULL})
            state_next = S_DONE;
          else state_next = S_ARD;
        end else state_next = S_XLATE;
      end
      S_XLATE: begin
        if (!map_rdata[PN]) state_next = S_DONE;
        else if (item.command == CMD_FREE) state_next = S_FRD;
        else if (item.command == CMD_READ) state_next = S_RAMRD;
        else state_next = S_DONE;
      end
      S_RAMRD:  state_next = S_DONE;
      S_ARD:    state_next = S_AEX;
      S_AEX: begin
        if (owner_rdata == 3'd0 && {1'b0, cnt} + 8'd1 == need) state_next = S_AEND;
        else state_next = S_ARD;
      end
      S_AEND:   state_next = S_DONE;
      S_FRD:    state_next = S_FEX;
      S_FEX: begin
        if (own_match && !link_rdata[PN] && cnt + 1'b1 != PG_FULL) state_next = S_FRD;
        else state_next = S_SRD;
      end
      S_SRD:    state_next = (bp_cur == '0) ? S_DONE : S_SEX;
      S_SEX:    state_next = map_rdata[PN] ? S_DONE : S_SRD;
      S_DONE:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Store control
  // --------------------------------------------------------------------------
  always_comb begin
    owner_we    = 1'b0;
    owner_waddr = scan_pg;
    owner_wdata = item.process_id;
    owner_raddr = scan_pg;
    link_we     = 1'b0;
    link_waddr  = prev_pg;
    link_wdata  = {1'b0, scan_pg};
    link_raddr  = walk_pg;
    map_we      = 1'b0;
    map_waddr   = {pidx, avpage};
    map_wdata   = {1'b1, scan_pg};
    map_raddr   = {pidx, vpage};
    ram_we      = 1'b0;
    ram_waddr   = {map_rdata[PN-1:0], item.address[OFFSET_BITS-1:0]};
    ram_wdata   = item.write_data;
    ram_raddr   = {map_rdata[PN-1:0], item.address[OFFSET_BITS-1:0]};
    unique case (state)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx;
        ram_wdata   = 8'd0;
        map_we      = ({1'b0, clr_idx} < MAP_LIM);
        map_waddr   = clr_idx[MAP_AW-1:0];
        map_wdata   = '0;
        owner_we    = ({1'b0, clr_idx} < PG_LIM);
        owner_waddr = clr_idx[PN-1:0];
        owner_wdata = 3'd0;
      end
      S_XLATE: ram_we = map_rdata[PN] && (item.command == CMD_WRITE);
      S_AEX: begin
        if (owner_rdata == 3'd0) begin
          owner_we = 1'b1;
          map_we   = 1'b1;
          link_we  = have_prev;
        end
      end
      S_AEND: begin
        link_we    = 1'b1;
        link_wdata = LINK_END;
      end
      S_FRD:   owner_raddr = walk_pg;
      S_FEX: begin
        if (own_match) begin
          owner_we    = 1'b1;
          owner_waddr = walk_pg;
          owner_wdata = 3'd0;
          map_we      = !vsum[PN];
          map_waddr   = {pidx, vsum[PN-1:0]};
          map_wdata   = '0;
        end
      end
      S_SRD:   map_raddr = {pidx, bp_dec[PN-1:0]};
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      free_cnt  <= PG_FULL;
      rsp_valid <= 1'b0;
      for (int n = 0; n < PROCESS_COUNT; n++) bp_reg[n] <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE && slot_free) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: if (req_valid) item <= req;
        S_DECODE: begin
          res_start  <= '0;
          res_data   <= 8'd0;
          need       <= need_calc;
          cnt        <= '0;
          scan_pg    <= '0;
          have_prev  <= 1'b0;
          if (!pid_ok) res_status <= ST_UNMAPPED;
          else if (item.command == CMD_ALLOC && item.size_bytes == 15'd0)
            res_status <= ST_BADSIZE;
          else if (item.command == CMD_ALLOC && state_next == S_DONE)
            res_status <= ST_NOMEM;
          else res_status <= ST_OK;
        end
        S_XLATE: begin
          walk_pg <= map_rdata[PN-1:0];
          if (!map_rdata[PN]) res_status <= ST_UNMAPPED;
        end
        S_RAMRD: res_data <= ram_rdata;
        S_AEX: begin
          if (owner_rdata == 3'd0) begin
            prev_pg   <= scan_pg;
            have_prev <= 1'b1;
            cnt       <= cnt + 1'b1;
          end
          scan_pg <= scan_pg + 1'b1;
        end
        S_AEND: begin
          res_start    <= {bp_cur[PN-1:0], {OFFSET_BITS{1'b0}}};
          bp_reg[pidx] <= bp_sum[PN:0];
          free_cnt     <= free_cnt - need[PN:0];
        end
        S_FEX: begin
          if (own_match) begin
            cnt      <= cnt + 1'b1;
            free_cnt <= free_cnt + 1'b1;
            walk_pg  <= link_rdata[PN-1:0];
          end
        end
        S_SEX: if (!map_rdata[PN]) bp_reg[pidx] <= bp_dec;
        S_DONE: begin
          if (slot_free) begin
            rsp.status       <= res_status;
            rsp.region_start <= res_start;
            rsp.read_data    <= res_data;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/pgmem_checker.sv @@
// ----------------------------------------------------------------------------
// pgmem_checker
// Port-level checks of the paged memory allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmem_checker (
  input wire              clk,
  input wire              rst,
  input wire              rsp_valid,
  input wire              rsp_stall,
  input pgmem_pkg::rsp_t  rsp
);
  import pgmem_pkg::*;

  // held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // region starts are page aligned
  a_start_align: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.region_start[OFFSET_BITS-1:0] == '0)
    else $error("region start not page aligned");

  // only a good transaction carries a start address
  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.region_start != '0 |-> rsp.status == ST_OK)
    else $error("start address on failed transaction");

  // only a good transaction carries read data
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.read_data != 8'd0 |-> rsp.status == ST_OK)
    else $error("read data on failed transaction");

endmodule

bind paged_memory_alloc_translate pgmem_checker u_pgmem_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
